// ===== rtl/core/wssr_pkg.sv =====
// ----------------------------------------------------------------------------
// wssr_pkg
// shared widths, ramp constants and constant-divider reciprocals for the
// wheel soft start / stop ramp core
// ----------------------------------------------------------------------------
package wssr_pkg;

  // field widths
  localparam int SPEED_W = 14;
  localparam int COUNT_W = 11;
  localparam int TGT_W   = 15;

  // ramp lengths in control ticks (1..2047)
  localparam int RAMP_UP_TICKS   = 1000;
  localparam int RAMP_DOWN_TICKS = 1500;

  // speed register reset value in rpm
  localparam logic [SPEED_W-1:0] SPEED_RESET = 14'd4890;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SPEED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SPEED = 2'd2;

  // speed * count product and its split for the reciprocal multiply
  localparam int PROD_W  = SPEED_W + COUNT_W;
  localparam int LO_W    = (PROD_W + 1) / 2;
  localparam int HI_W    = PROD_W - LO_W;
  localparam int RECIP_W = PROD_W + 2;
  localparam int SUM_W   = PROD_W + RECIP_W;

  // q = (p * ceil(2^s / d)) >> s is exact for p * d < 2^s
  localparam int UP_SHIFT   = PROD_W + $clog2(RAMP_UP_TICKS);
  localparam int DOWN_SHIFT = PROD_W + $clog2(RAMP_DOWN_TICKS);
  localparam longint unsigned UP_RECIP_L =
    ((64'd1 << UP_SHIFT) + 64'(RAMP_UP_TICKS) - 64'd1) / 64'(RAMP_UP_TICKS);
  localparam longint unsigned DOWN_RECIP_L =
    ((64'd1 << DOWN_SHIFT) + 64'(RAMP_DOWN_TICKS) - 64'd1) / 64'(RAMP_DOWN_TICKS);
  localparam logic [RECIP_W-1:0] UP_RECIP   = RECIP_W'(UP_RECIP_L);
  localparam logic [RECIP_W-1:0] DOWN_RECIP = RECIP_W'(DOWN_RECIP_L);

  // per-item control info that travels down the pipeline
  typedef struct packed {
    logic sel_down;  // scale by the down ramp divisor
    logic hold;      // keep the previous targets
    logic off;       // drive off flag after this tick
    logic ready;     // wheels ready flag after this tick
  } wssr_side_t;

  typedef struct packed {
    logic [COUNT_W-1:0] num;
    wssr_side_t         side;
  } wssr_item_t;

  // stage load enables for the scaling pipeline
  typedef struct packed {
    logic en_b;
    logic en_c;
  } wssr_pipe_en_t;

endpackage

// ===== rtl/core/wssr_ctrl.sv =====
// ----------------------------------------------------------------------------
// wssr_ctrl
// ramp counters, ready / off flags and the first pipeline register
// ----------------------------------------------------------------------------
module wssr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                links_online,
  input  logic                base_ready,
  output wssr_pkg::wssr_item_t item
);

  localparam logic [wssr_pkg::COUNT_W-1:0] UP_END =
    wssr_pkg::COUNT_W'(wssr_pkg::RAMP_UP_TICKS);
  localparam logic [wssr_pkg::COUNT_W-1:0] DOWN_END =
    wssr_pkg::COUNT_W'(wssr_pkg::RAMP_DOWN_TICKS);

  logic [wssr_pkg::COUNT_W-1:0] up_count, up_count_next;
  logic [wssr_pkg::COUNT_W-1:0] down_count, down_count_next;
  logic                         ready_flag, ready_flag_next;
  logic                         off_flag, off_flag_next;
  wssr_pkg::wssr_item_t         item_next;

  always_comb begin
    up_count_next   = up_count;
    down_count_next = down_count;
    off_flag_next   = off_flag;
    ready_flag_next = ready_flag | (base_ready & (up_count == UP_END));
    item_next       = '0;
    if (links_online && base_ready) begin
      off_flag_next   = 1'b0;
      down_count_next = '0;
      if (up_count < UP_END) begin
        up_count_next = up_count + 1'b1;
      end else begin
        up_count_next = UP_END;
      end
      item_next.num = up_count_next;
    end else if (ready_flag_next) begin
      up_count_next          = '0;
      item_next.side.sel_down = 1'b1;
      if (down_count < DOWN_END) begin
        down_count_next = down_count + 1'b1;
        item_next.num   = DOWN_END - down_count_next;
      end else begin
        down_count_next      = DOWN_END;
        ready_flag_next      = 1'b0;
        item_next.side.hold  = 1'b1;
      end
    end else begin
      off_flag_next       = 1'b1;
      item_next.side.hold = 1'b1;
    end
    item_next.side.off   = off_flag_next;
    item_next.side.ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_count   <= '0;
      down_count <= '0;
      ready_flag <= 1'b0;
      off_flag   <= 1'b0;
    end else if (accept) begin
      up_count   <= up_count_next;
      down_count <= down_count_next;
      ready_flag <= ready_flag_next;
      off_flag   <= off_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

  // counters never pass their ramp ends
  a_count_bounds: assert property (@(posedge clk) disable iff (rst)
    (up_count <= UP_END) && (down_count <= DOWN_END))
    else $error("ramp counter beyond its end");

  // one ramp at a time: a run clears the down count, a stop clears the up count
  a_count_excl: assert property (@(posedge clk) disable iff (rst)
    (up_count == '0) || (down_count == '0))
    else $error("up and down counters both active");

  // a down ramp part way through only runs while the wheels are ready
  a_down_ready: assert property (@(posedge clk) disable iff (rst)
    ((down_count != '0) && (down_count != DOWN_END)) |-> ready_flag)
    else $error("down ramp in progress without ready flag");

endmodule

// ===== rtl/core/wssr_scale.sv =====
// ----------------------------------------------------------------------------
// wssr_scale
// one wheel: speed * count product, split reciprocal multiply, quotient
// ----------------------------------------------------------------------------
module wssr_scale (
  input  logic                          clk,
  input  wssr_pkg::wssr_pipe_en_t        en,
  input  logic                          sel_b,
  input  logic                          sel_c,
  input  logic [wssr_pkg::SPEED_W-1:0]  speed,
  input  logic [wssr_pkg::COUNT_W-1:0]  num,
  output logic [wssr_pkg::SPEED_W-1:0]  quot
);

  logic [wssr_pkg::PROD_W-1:0]                    prod;
  logic [wssr_pkg::RECIP_W-1:0]                   recip;
  logic [wssr_pkg::HI_W+wssr_pkg::RECIP_W-1:0]    pp_hi;
  logic [wssr_pkg::LO_W+wssr_pkg::RECIP_W-1:0]    pp_lo;
  logic [wssr_pkg::SUM_W-1:0]                     sum;

  // stage b: magnitude times ramp numerator
  always_ff @(posedge clk) begin
    if (en.en_b) begin
      prod <= wssr_pkg::PROD_W'(speed) * wssr_pkg::PROD_W'(num);
    end
  end

  assign recip = sel_b ? wssr_pkg::DOWN_RECIP : wssr_pkg::UP_RECIP;

  // stage c: partial products with the divisor reciprocal
  always_ff @(posedge clk) begin
    if (en.en_c) begin
      pp_hi <= (wssr_pkg::HI_W + wssr_pkg::RECIP_W)'(
                 prod[wssr_pkg::PROD_W-1:wssr_pkg::LO_W]) *
               (wssr_pkg::HI_W + wssr_pkg::RECIP_W)'(recip);
      pp_lo <= (wssr_pkg::LO_W + wssr_pkg::RECIP_W)'(prod[wssr_pkg::LO_W-1:0]) *
               (wssr_pkg::LO_W + wssr_pkg::RECIP_W)'(recip);
    end
  end

  assign sum = (wssr_pkg::SUM_W'(pp_hi) << wssr_pkg::LO_W) + wssr_pkg::SUM_W'(pp_lo);

  assign quot = sel_c ? wssr_pkg::SPEED_W'(sum >> wssr_pkg::DOWN_SHIFT)
                      : wssr_pkg::SPEED_W'(sum >> wssr_pkg::UP_SHIFT);

endmodule

// ===== rtl/core/wheel_soft_start_stop_ramp_core.sv =====
// ----------------------------------------------------------------------------
// wheel_soft_start_stop_ramp_core
// soft start / soft stop speed ramp for three friction wheels
// ----------------------------------------------------------------------------
// one transaction on the input stream is one control tick and yields exactly
// one result transaction carrying the three ramped wheel targets (top and left
// negated, right positive), the drive off flag and the wheels ready flag. the
// block takes one tick per clock cycle unless stalled. ticks pass four
// register stages: ramp counters, speed times ramp count, reciprocal multiply
// for the constant ramp divisor, output register. a stage only stalls when
// the next stage is full, so ticks keep flowing into empty stages while a
// result waits on the output. the user must write speed registers through
// the cfg port only while no tick is in flight; the block does not enforce it.
module wheel_soft_start_stop_ramp_core (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [wssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wssr_pkg::SPEED_W-1:0]     cfg_wdata,
  // tick stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // links_online, base_ready
  // target stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [47:0]                      m_tdata   // target_top, target_left,
                                                     // target_right, drive_off,
                                                     // wheels_ready
);

  localparam int NW = 3;

  // speed registers
  logic [wssr_pkg::SPEED_W-1:0] speed [NW];

  // pipeline valid and ready chain
  logic v_a, v_b, v_c;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic accept;
  wssr_pkg::wssr_pipe_en_t pipe_en;

  wssr_pkg::wssr_item_t item_a;
  wssr_pkg::wssr_side_t side_b, side_c;

  logic [wssr_pkg::SPEED_W-1:0] quot [NW];

  // held targets double as the output payload
  logic [wssr_pkg::TGT_W-1:0] tgt [NW];
  logic [wssr_pkg::TGT_W-1:0] tgt_new [NW];
  logic                       drive_off;
  logic                       wheels_ready;
  logic                       out_v;

  // config writes, unlisted indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NW; i++) begin
        speed[i] <= wssr_pkg::SPEED_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        wssr_pkg::CFG_TOP_SPEED:   speed[0] <= cfg_wdata;
        wssr_pkg::CFG_LEFT_SPEED:  speed[1] <= cfg_wdata;
        wssr_pkg::CFG_RIGHT_SPEED: speed[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or the next one moves on
  assign rdy_d    = !out_v || m_tready;
  assign rdy_c    = !v_c || rdy_d;
  assign rdy_b    = !v_b || rdy_c;
  assign rdy_a    = !v_a || rdy_b;
  assign s_tready = rdy_a;
  assign accept   = s_tvalid && rdy_a;

  assign pipe_en.en_b = rdy_b;
  assign pipe_en.en_c = rdy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a   <= 1'b0;
      v_b   <= 1'b0;
      v_c   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (rdy_a) v_a   <= s_tvalid;
      if (rdy_b) v_b   <= v_a;
      if (rdy_c) v_c   <= v_b;
      if (rdy_d) out_v <= v_c;
    end
  end

  // stage a: counters and flags, registered per tick
  wssr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .links_online (s_tdata[0]),
    .base_ready   (s_tdata[1]),
    .item         (item_a)
  );

  // control info follows the scaling stages
  always_ff @(posedge clk) begin
    if (rdy_b) side_b <= item_a.side;
    if (rdy_c) side_c <= side_b;
  end

  // stages b and c per wheel
  for (genvar w = 0; w < NW; w++) begin : g_wheel
    wssr_scale u_scale (
      .clk   (clk),
      .en    (pipe_en),
      .sel_b (side_b.sel_down),
      .sel_c (side_c.sel_down),
      .speed (speed[w]),
      .num   (item_a.num),
      .quot  (quot[w])
    );
  end

  // top and left wheels run reversed
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      if (side_c.hold) begin
        tgt_new[i] = tgt[i];
      end else if (i == NW - 1) begin
        tgt_new[i] = {1'b0, quot[i]};
      end else begin
        tgt_new[i] = wssr_pkg::TGT_W'(0) - {1'b0, quot[i]};
      end
    end
  end

  // stage d: output register, targets reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NW; i++) begin
        tgt[i] <= '0;
      end
      drive_off    <= 1'b0;
      wheels_ready <= 1'b0;
    end else if (rdy_d && v_c) begin
      for (int i = 0; i < NW; i++) begin
        tgt[i] <= tgt_new[i];
      end
      drive_off    <= side_c.off;
      wheels_ready <= side_c.ready;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {1'b0, wheels_ready, drive_off, tgt[2], tgt[1], tgt[0]};

endmodule
